// ===== src/sism_pkg.sv =====
// Package for the sorted ID set membership unit.
// Holds opcode, status and sequencer state types, the invalid ID and register indices. No dependencies.
package sism_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_APPEND   = 3'd1,
    OP_SORT     = 3'd2,
    OP_QUERY_FS = 3'd3,
    OP_QUERY_EF = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_STRIDE,
    S_BASE,
    S_HOLD_WAIT,
    S_PREV_RD,
    S_PREV_CMP,
    S_PLACE,
    S_OUT
  } state_e;

  localparam logic [31:0] INVALID_ID = 32'hFFFF_FFFF;
  localparam logic [1:0]  REG_FS_ID  = 2'd0;
  localparam logic [1:0]  REG_EF_ID  = 2'd1;

endpackage

// ===== src/sorted_id_set_membership_unit.sv =====
// Sorted ID set membership unit: ID table in one synchronous RAM,
// append / clear / Shell sort / query (config register match or binary search). Uses sism_pkg.
// Clear, append and unused opcodes go from idle straight to the output state.
// A query runs a binary search, a read and a compare state per probe, paced by
// the single RAM read port. Sort: a stride state per pass, base, hold-wait, read,
// compare and place per insertion step, another read and compare per move; data dependent.
// One transaction at a time; the result sits in an output register while the next waits.
// Reset clears the count, config registers and control; the RAM itself is not cleared.
module sorted_id_set_membership_unit #(
  parameter int MAX_IDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] id_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_member_o,
  output logic [1:0]  status_o,
  output logic [10:0] entry_count_o
);

  localparam int AW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int CW = $clog2(MAX_IDS + 1) + 1;  // count plus head room for lo+hi

  // ---------------- configuration registers ----------------
  // registers sit at byte addresses 0 and 4, so paddr[2] is the index
  logic [31:0] fs_id_q, ef_id_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = {1'b0, paddr[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_id_q <= '0;
      ef_id_q <= '0;
    end else if (cfg_wr) begin
      if (cfg_idx == sism_pkg::REG_FS_ID) fs_id_q <= pwdata;
      if (cfg_idx == sism_pkg::REG_EF_ID) ef_id_q <= pwdata;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sism_pkg::REG_FS_ID: prdata = fs_id_q;
      sism_pkg::REG_EF_ID: prdata = ef_id_q;
      default:             prdata = '0;
    endcase
  end

  // ---------------- ID table RAM ----------------
  logic [31:0] mem [MAX_IDS];
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // ---------------- control ----------------
  sism_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [2:0]    op_q;
  logic [31:0]   key_q;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d;      // search bounds
  logic [CW-1:0] stride_q, stride_d;          // Shell stride
  logic [3:0]    lvl_q, lvl_d;                // position of stride in 1,4,13,...
  logic [CW-1:0] base_q, base_d, pos_q, pos_d;
  logic [31:0]   hold_q, hold_d;
  logic          member_q, member_d;
  logic [1:0]    status_q, status_d;
  logic          out_v_q;
  logic [CW-1:0] mid;
  logic [CW:0]   lohi;
  logic          accept;

  assign in_stall_o = (state_q != sism_pkg::S_IDLE) || out_v_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign lohi       = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid        = lohi[CW:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sism_pkg::S_IDLE;
      count_q  <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == sism_pkg::S_OUT) out_v_q <= 1'b1;
      else if (!out_stall_i)          out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      key_q <= id_value_i;
    end
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    stride_q <= stride_d;
    lvl_q    <= lvl_d;
    base_q   <= base_d;
    pos_q    <= pos_d;
    hold_q   <= hold_d;
    member_q <= member_d;
    status_q <= status_d;
  end

  // stride sequence h = 3h + 1 as a constant table; level 0 means done
  function automatic logic [31:0] stride_of(input logic [3:0] lvl);
    logic [31:0] s;
    case (lvl)
      4'd1:    s = 32'd1;
      4'd2:    s = 32'd4;
      4'd3:    s = 32'd13;
      4'd4:    s = 32'd40;
      4'd5:    s = 32'd121;
      4'd6:    s = 32'd364;
      4'd7:    s = 32'd1093;
      4'd8:    s = 32'd3280;
      4'd9:    s = 32'd9841;
      4'd10:   s = 32'd29524;
      4'd11:   s = 32'd88573;
      default: s = 32'd0;
    endcase
    return s;
  endfunction

  // first stride: largest term strictly below n, none when n < 2
  function automatic logic [3:0] init_level(input logic [CW-1:0] n);
    logic [3:0] lvl;
    lvl = 4'd0;
    for (int k = 1; k < 12; k++)
      if (stride_of(4'(k)) < 32'(n)) lvl = 4'(k);
    return lvl;
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sism_pkg::S_IDLE: if (accept) begin
        if (opcode_i == sism_pkg::OP_SORT) state_d = sism_pkg::S_STRIDE;
        else if (opcode_i == sism_pkg::OP_QUERY_FS || opcode_i == sism_pkg::OP_QUERY_EF)
          state_d = sism_pkg::S_SRCH_RD;
        else state_d = sism_pkg::S_OUT;
      end
      sism_pkg::S_SRCH_RD:
        state_d = (member_q || lo_q >= hi_q) ? sism_pkg::S_OUT : sism_pkg::S_SRCH_CMP;
      sism_pkg::S_SRCH_CMP: state_d = sism_pkg::S_SRCH_RD;
      sism_pkg::S_STRIDE:
        state_d = (stride_q == '0) ? sism_pkg::S_OUT : sism_pkg::S_BASE;
      sism_pkg::S_BASE:
        state_d = (base_q + stride_q < count_q) ? sism_pkg::S_HOLD_WAIT : sism_pkg::S_STRIDE;
      sism_pkg::S_HOLD_WAIT:
        state_d = (pos_q >= stride_q) ? sism_pkg::S_PREV_RD : sism_pkg::S_PLACE;
      sism_pkg::S_PREV_RD:  state_d = sism_pkg::S_PREV_CMP;
      sism_pkg::S_PREV_CMP:
        state_d = (rdata_q > hold_q) ?
                  ((pos_q - stride_q >= stride_q) ? sism_pkg::S_PREV_RD : sism_pkg::S_PLACE)
                  : sism_pkg::S_PLACE;
      sism_pkg::S_PLACE: state_d = sism_pkg::S_BASE;
      sism_pkg::S_OUT:   state_d = sism_pkg::S_IDLE;
      default:           state_d = sism_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d  = count_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    lvl_d    = lvl_q;
    base_d   = base_q;
    pos_d    = pos_q;
    hold_d   = hold_q;
    member_d = member_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = pos_q[AW-1:0];
    wdata    = hold_q;
    raddr    = mid[AW-1:0];
    unique case (state_q)
      sism_pkg::S_IDLE: begin
        lo_d     = '0;
        hi_d     = count_q;
        base_d   = '0;
        // result fields hold until the next transaction is taken
        if (accept) begin
          member_d = 1'b0;
          status_d = sism_pkg::ST_OK;
          unique case (opcode_i)
            sism_pkg::OP_CLEAR: count_d = '0;
            sism_pkg::OP_APPEND: begin
              if (id_value_i == sism_pkg::INVALID_ID) status_d = sism_pkg::ST_INVALID;
              else if (count_q >= CW'(MAX_IDS))       status_d = sism_pkg::ST_FULL;
              else begin
                we      = 1'b1;
                waddr   = count_q[AW-1:0];
                wdata   = id_value_i;
                count_d = count_q + 1'b1;
              end
            end
            sism_pkg::OP_SORT: lvl_d = init_level(count_q);
            sism_pkg::OP_QUERY_FS: member_d = (id_value_i == fs_id_q);
            sism_pkg::OP_QUERY_EF: member_d = (id_value_i == ef_id_q);
            default: ;
          endcase
        end
      end
      sism_pkg::S_SRCH_RD: raddr = mid[AW-1:0];
      sism_pkg::S_SRCH_CMP: begin
        if (key_q > rdata_q)      lo_d = mid + 1'b1;
        else if (key_q < rdata_q) hi_d = mid;
        else                      member_d = 1'b1;
      end
      sism_pkg::S_STRIDE: begin
        base_d = '0;
      end
      sism_pkg::S_BASE: begin
        pos_d = base_q + stride_q;
        raddr = pos_d[AW-1:0];
        // pass done: step down to the previous stride term
        if (!(base_q + stride_q < count_q)) lvl_d = lvl_q - 1'b1;
      end
      sism_pkg::S_HOLD_WAIT: begin
        hold_d = rdata_q;
        raddr  = pos_q[AW-1:0] - stride_q[AW-1:0];
      end
      sism_pkg::S_PREV_RD: raddr = pos_q[AW-1:0] - stride_q[AW-1:0];
      sism_pkg::S_PREV_CMP: begin
        if (rdata_q > hold_q) begin
          we    = 1'b1;
          waddr = pos_q[AW-1:0];
          wdata = rdata_q;
          pos_d = pos_q - stride_q;
          raddr = pos_d[AW-1:0] - stride_q[AW-1:0];
        end
      end
      sism_pkg::S_PLACE: begin
        we     = 1'b1;
        waddr  = pos_q[AW-1:0];
        wdata  = hold_q;
        base_d = base_q + 1'b1;
      end
      default: ;
    endcase
    stride_d = CW'(stride_of(lvl_d));
  end

  assign out_valid_o   = out_v_q;
  assign is_member_o   = member_q;
  assign status_o      = status_q;
  assign entry_count_o = 11'(count_q);

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_IDS)) else $error("count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !accept) else $error("accepted while result pending");
  a_member_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && member_q) |-> (op_q == sism_pkg::OP_QUERY_FS || op_q == sism_pkg::OP_QUERY_EF))
    else $error("member flag outside query");
`endif

endmodule

// ===== test/tb_sorted_id_set_membership_unit.sv =====
// Testbench for the sorted ID set membership unit: directed table, then random traffic,
// checked against a behavioral predictor of the ID table. Depends on sism_pkg and the RTL.
module tb_sorted_id_set_membership_unit;

  localparam int MAX_IDS   = 1024;
  localparam int N_RANDOM  = 300;
  localparam int CYC_LIMIT = 2000000;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid_i, in_stall_o;
  logic [2:0]  opcode_i;
  logic [31:0] id_value_i;
  logic        out_valid_o, out_stall_i;
  logic        is_member_o;
  logic [1:0]  status_o;
  logic [10:0] entry_count_o;

  sorted_id_set_membership_unit #(.MAX_IDS(MAX_IDS)) u_top (.*);

  typedef struct packed {
    logic        member;
    logic [1:0]  status;
    logic [10:0] count;
  } answer_t;

  // predictor state
  logic [31:0] id_mem [MAX_IDS];
  int unsigned n_ids;
  logic [31:0] fs_reg, ef_reg;

  answer_t answer_q[$];
  int      n_errors, n_checked, n_hits, n_invalid, n_sorts;
  int      cycles;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void shell_sort_ids();
    int unsigned stride, base, pos;
    logic [31:0] hold;
    stride = 1;
    while (stride < n_ids) stride = 3 * stride + 1;
    stride = stride / 3;
    while (stride != 0) begin
      for (base = 0; base + stride < n_ids; base++) begin
        pos  = base + stride;
        hold = id_mem[pos];
        while (pos >= stride && id_mem[pos - stride] > hold) begin
          id_mem[pos] = id_mem[pos - stride];
          pos -= stride;
        end
        id_mem[pos] = hold;
      end
      stride = stride / 3;
    end
  endfunction

  function automatic bit search_ids(logic [31:0] key);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = n_ids;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (key > id_mem[mid]) lo = mid + 1;
      else if (key < id_mem[mid]) hi = mid;
      else return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work out the answer one transaction gives and update the table model.
  function automatic answer_t predict_answer(logic [2:0] op, logic [31:0] id);
    answer_t a;
    a = '0;
    case (op)
      sism_pkg::OP_CLEAR:  n_ids = 0;
      sism_pkg::OP_APPEND: begin
        if (id == sism_pkg::INVALID_ID) a.status = sism_pkg::ST_INVALID;
        else if (n_ids >= MAX_IDS) a.status = sism_pkg::ST_FULL;
        else begin
          id_mem[n_ids] = id;
          n_ids++;
        end
      end
      sism_pkg::OP_SORT:     shell_sort_ids();
      sism_pkg::OP_QUERY_FS: a.member = (id == fs_reg) || search_ids(id);
      sism_pkg::OP_QUERY_EF: a.member = (id == ef_reg) || search_ids(id);
      default: ;
    endcase
    a.count = n_ids[10:0];
    return a;
  endfunction

  // Result side: random stall, compare each transaction with the oldest answer.
  initial begin
    int      wait_cyc;
    answer_t exp_a;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      wait_cyc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      out_stall_i <= (wait_cyc != 0);
      repeat (wait_cyc) @(posedge clk_i);
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result member=%0b status=%0d count=%0d",
                 $time, is_member_o, status_o, entry_count_o);
        n_errors++;
      end else begin
        exp_a = answer_q.pop_front();
        n_checked++;
        if (is_member_o !== exp_a.member) begin
          $display("%0t: is_member expected %0b got %0b", $time, exp_a.member, is_member_o);
          n_errors++;
        end
        if (status_o !== exp_a.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_a.status, status_o);
          n_errors++;
        end
        if (entry_count_o !== exp_a.count) begin
          $display("%0t: entry_count expected %0d got %0d", $time, exp_a.count,
                   entry_count_o);
          n_errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx[0], 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == sism_pkg::REG_FS_ID) fs_reg = val;
    else ef_reg = val;
    @(posedge clk_i);
  endtask

  // Send one transaction; the answer is queued at the accepting edge.
  // Valid stays up after acceptance unless a gap follows; drain drops it.
  task automatic send_item(logic [2:0] op, logic [31:0] id);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    id_value_i <= id;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    answer_q.push_back(predict_answer(op, id));
  endtask

  // Directed row: expected typed in where obvious, else the predictor decides.
  task automatic send_row(logic [2:0] op, logic [31:0] id, bit typed, answer_t typed_a);
    answer_t p;
    if (typed) begin
      send_item(op, id);
      p = answer_q[$];
      if (p !== typed_a) begin
        $display("%0t: directed row op=%0d expected %h predicted %h", $time, op, typed_a, p);
        n_errors++;
      end
    end else
      send_item(op, id);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_id();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFF0 | $urandom_range(0, 14);
      default: return $urandom;
    endcase
  endfunction

  typedef struct {
    logic [2:0]  op;
    logic [31:0] id;
    bit          typed;
    answer_t     a;
  } row_t;

  initial begin
    row_t        rows[$];
    logic [31:0] held[$];
    logic [2:0]  op;
    logic [31:0] id;
    int          sent, burst;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; opcode_i = sism_pkg::OP_CLEAR; id_value_i = '0;
    n_ids = 0; fs_reg = '0; ef_reg = '0; cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: registers are 0, table empty
    rows = '{
      '{sism_pkg::OP_QUERY_FS, 32'h0, 1, '{1'b1, sism_pkg::ST_OK, 11'd0}},
      '{sism_pkg::OP_QUERY_EF, 32'h5, 1, '{1'b0, sism_pkg::ST_OK, 11'd0}},
      '{sism_pkg::OP_APPEND, 32'hFFFF_FFFF, 1, '{1'b0, sism_pkg::ST_INVALID, 11'd0}},
      '{sism_pkg::OP_APPEND, 32'hFFFF_FFFE, 1, '{1'b0, sism_pkg::ST_OK, 11'd1}},
      '{sism_pkg::OP_APPEND, 32'h0, 1, '{1'b0, sism_pkg::ST_OK, 11'd2}},
      '{sism_pkg::OP_APPEND, 32'h8000_0000, 0, '0},
      '{sism_pkg::OP_APPEND, 32'h1234_5678, 0, '0},
      '{sism_pkg::OP_QUERY_FS, 32'h1234_5678, 0, '0},
      '{sism_pkg::OP_SORT, 32'h0, 1, '{1'b0, sism_pkg::ST_OK, 11'd4}},
      '{sism_pkg::OP_QUERY_FS, 32'hFFFF_FFFE, 0, '0},
      '{sism_pkg::OP_QUERY_EF, 32'h8000_0000, 0, '0},
      '{sism_pkg::OP_QUERY_EF, 32'hFFFF_FFFF, 0, '0},
      '{3'd5, 32'h1, 1, '{1'b0, sism_pkg::ST_OK, 11'd4}},
      '{3'd6, 32'hFFFF_FFFF, 1, '{1'b0, sism_pkg::ST_OK, 11'd4}},
      '{3'd7, 32'hAAAA_5555, 1, '{1'b0, sism_pkg::ST_OK, 11'd4}},
      '{sism_pkg::OP_CLEAR, 32'h0, 1, '{1'b0, sism_pkg::ST_OK, 11'd0}},
      '{sism_pkg::OP_QUERY_EF, 32'h1234_5678, 1, '{1'b0, sism_pkg::ST_OK, 11'd0}}
    };
    foreach (rows[i]) send_row(rows[i].op, rows[i].id, rows[i].typed, rows[i].a);
    drain();

    // extremes of both registers
    write_reg(sism_pkg::REG_FS_ID, 32'hFFFF_FFFF);
    write_reg(sism_pkg::REG_EF_ID, 32'hFFFF_FFFF);
    send_row(sism_pkg::OP_QUERY_FS, 32'hFFFF_FFFF, 1, '{1'b1, sism_pkg::ST_OK, 11'd0});
    send_row(sism_pkg::OP_QUERY_EF, 32'hFFFF_FFFF, 1, '{1'b1, sism_pkg::ST_OK, 11'd0});
    drain();

    // fill the table to MAX_IDS, then hit the full case
    for (int i = 0; i < MAX_IDS; i++)
      send_item(sism_pkg::OP_APPEND, $urandom_range(0, 32'hFFFF_FFFE));
    send_row(sism_pkg::OP_APPEND, 32'h42, 1, '{1'b0, sism_pkg::ST_FULL, 11'd1024});
    send_row(sism_pkg::OP_APPEND, 32'hFFFF_FFFF, 1,
             '{1'b0, sism_pkg::ST_INVALID, 11'd1024});
    send_item(sism_pkg::OP_QUERY_FS, id_mem[17]);
    send_item(sism_pkg::OP_SORT, 32'h0);
    send_item(sism_pkg::OP_QUERY_EF, id_mem[500]);
    send_item(sism_pkg::OP_QUERY_FS, id_mem[MAX_IDS - 1]);
    send_item(sism_pkg::OP_CLEAR, 32'h0);
    drain();

    // random phases: small tables built, sorted and probed; new registers each phase
    sent = 0;
    while (sent < N_RANDOM) begin
      write_reg(sism_pkg::REG_FS_ID, ($urandom_range(0, 1)) ? rand_id() : 32'h0);
      write_reg(sism_pkg::REG_EF_ID, rand_id());
      held.delete();
      burst = $urandom_range(20, 80);
      for (int k = 0; k < burst && sent < N_RANDOM; k++, sent++) begin
        case ($urandom_range(0, 19))
          0: op = sism_pkg::OP_CLEAR;
          1, 2: op = sism_pkg::OP_SORT;
          3: op = 3'($urandom_range(5, 7));
          4, 5, 6, 7, 8, 9: op = sism_pkg::OP_APPEND;
          default: op = ($urandom_range(0, 1)) ? sism_pkg::OP_QUERY_FS : sism_pkg::OP_QUERY_EF;
        endcase
        if ((op == sism_pkg::OP_QUERY_FS || op == sism_pkg::OP_QUERY_EF) && held.size() != 0
            && $urandom_range(0, 1))
          id = held[$urandom_range(0, held.size() - 1)];
        else if (op == sism_pkg::OP_QUERY_FS && $urandom_range(0, 9) == 0) id = fs_reg;
        else if (op == sism_pkg::OP_QUERY_EF && $urandom_range(0, 9) == 0) id = ef_reg;
        else id = ($urandom_range(0, 30) == 0) ? 32'hFFFF_FFFF : rand_id();
        if (op == sism_pkg::OP_APPEND) held.push_back(id);
        if (op == sism_pkg::OP_CLEAR) held.delete();
        send_item(op, id);
        if ((op == sism_pkg::OP_QUERY_FS || op == sism_pkg::OP_QUERY_EF)
            && answer_q[$].member) n_hits++;
        if (op == sism_pkg::OP_APPEND && answer_q[$].status == sism_pkg::ST_INVALID)
          n_invalid++;
        if (op == sism_pkg::OP_SORT) n_sorts++;
      end
      drain();
    end

    drain();
    $display("checked %0d results: %0d random query hits, %0d sorts, %0d invalid appends,",
             n_checked, n_hits, n_sorts, n_invalid);
    $display("plus a full 1024-entry table and register extremes");
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sism_pkg.sv
src/sorted_id_set_membership_unit.sv
test/tb_sorted_id_set_membership_unit.sv
